>>> rtl/iac_pkg.sv
package iac_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  // Q2.14 unity
  localparam int ONE_Q = 16384;

  localparam int MAG_W  = 17;          // axis magnitude, a little headroom above one
  localparam int OPD_W  = 18;          // multiplier operand width
  localparam int MUL_W  = 2 * OPD_W;   // multiplier product width
  localparam int LEN2_W = 35;          // sum of two squared magnitudes
  localparam int ROOT_W = 18;          // rounded square root of LEN2_W bits
  localparam int DEN_W  = 32;          // divisor width
  localparam int DVD_W  = 48;          // dividend width
  localparam int QUO_W  = 17;          // quotient width

  localparam logic [2:0] KIND_BUTTON  = 3'd0;
  localparam logic [2:0] KIND_BAXIS1D = 3'd1;
  localparam logic [2:0] KIND_BAXIS2D = 3'd2;
  localparam logic [2:0] KIND_ANA1D   = 3'd3;
  localparam logic [2:0] KIND_ANA2D   = 3'd4;

endpackage

>>> rtl/iac_flag_mem.sv
module iac_flag_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [iac_pkg::SLOT_W-1:0] rd_addr_i,
  output logic                      rd_data_o,
  input  logic                      wr_en_i,
  input  logic [iac_pkg::SLOT_W-1:0] wr_addr_i,
  input  logic                      wr_data_i
);
  import iac_pkg::*;

  logic                  mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_q;
  logic                  mem_rd_q;
  logic                  vld_rd_q;

  // Entries never written since reset read as not pressed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_rd_q <= mem[rd_addr_i];
      vld_rd_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = mem_rd_q & vld_rd_q;

endmodule

>>> rtl/iac_sqrt.sv
module iac_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [iac_pkg::LEN2_W-1:0] rad_i,
  output logic                       done_o,
  output logic [iac_pkg::ROOT_W-1:0] root_o
);
  import iac_pkg::*;

  localparam int RW = LEN2_W + 1;
  localparam int TOP_BIT = ((LEN2_W - 1) / 2) * 2;

  logic          busy_q, busy_d;
  logic          rnd_q, rnd_d;
  logic          done_q, done_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] r_q, r_d;
  logic [RW-1:0] bit_q, bit_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [RW-1:0] trial;

  assign trial = r_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    rnd_d  = 1'b0;
    done_d = 1'b0;
    rem_d  = rem_q;
    r_d    = r_q;
    bit_d  = bit_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = RW'(rad_i);
      r_d    = '0;
      bit_d  = RW'(1) << TOP_BIT;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        r_d   = (r_q >> 1) + bit_q;
      end else begin
        r_d   = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        rnd_d  = 1'b1;
      end
    end else if (rnd_q) begin
      // Round to nearest: the remainder exceeds r exactly when s > r*r + r.
      root_d = ROOT_W'(r_q) + ROOT_W'(rem_q > r_q);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rnd_q  <= rnd_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> rtl/iac_div.sv
module iac_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [iac_pkg::DVD_W-1:0] dvd_i,
  input  logic [iac_pkg::DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [iac_pkg::QUO_W-1:0] quo_o
);
  import iac_pkg::*;

  localparam int SW = DVD_W + 1;
  localparam int CW = $clog2(QUO_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DVD_W-1:0]  rem_q, rem_d;
  logic [SW-1:0]     dsh_q, dsh_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic              ge;

  assign ge = {1'b0, rem_q} >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dvd_i;
      dsh_d  = SW'(den_i) << (QUO_W - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - DVD_W'(dsh_q);
      end
      quo_d = {quo_q[QUO_W-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/input_action_conditioner.sv
// The result of an item is registered soonest for button kinds inside the unit circle and
// latest for an analog stick outside the deadzone that is then normalised, set by the
// bit-serial square root and the bit-serial divider (one bit per cycle).
// Throughput: one item at a time; a result that is still stalled in the output register
// holds the next item in its final state.
// Reset (asynchronous, active low) clears the control state and marks every slot as not pressed.
module input_action_conditioner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 slot_i,
  input  logic [2:0]                 kind_i,
  input  logic                       level_a_i,
  input  logic                       level_b_i,
  input  logic                       level_c_i,
  input  logic                       level_d_i,
  input  logic                       pad_connected_i,
  input  logic signed [15:0]         stick_x_i,
  input  logic signed [15:0]         stick_y_i,
  input  logic [13:0]                dead_zone_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [15:0]         value_x_o,
  output logic signed [15:0]         value_y_o,
  output logic                       active_o,
  output logic                       press_edge_o,
  output logic                       release_edge_o
);
  import iac_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQX  = 4'd1;
  localparam logic [3:0] ST_SQY  = 4'd2;
  localparam logic [3:0] ST_DZ   = 4'd3;
  localparam logic [3:0] ST_ROOT = 4'd4;
  localparam logic [3:0] ST_DEN  = 4'd5;
  localparam logic [3:0] ST_NUMX = 4'd6;
  localparam logic [3:0] ST_DIVX = 4'd7;
  localparam logic [3:0] ST_NUMY = 4'd8;
  localparam logic [3:0] ST_DIVY = 4'd9;
  localparam logic [3:0] ST_NCHK = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  localparam logic [LEN2_W-1:0] ONE_SQ = LEN2_W'(ONE_Q) * LEN2_W'(ONE_Q);
  localparam logic [MAG_W-1:0]  ONE_M  = MAG_W'(ONE_Q);

  logic [3:0]          state_q, state_d;
  logic                ana_q, ana_d;     // analog rescale still pending
  logic                norm_q, norm_d;   // working on the final normalisation
  logic                old_q, old_d;     // pressed bit of the slot before this item
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [13:0]         dz_q, dz_d;
  logic                sgn_x_q, sgn_x_d, sgn_y_q, sgn_y_d;
  logic [MAG_W-1:0]    mx_q, mx_d, my_q, my_d;
  logic [LEN2_W-1:0]   len2_q, len2_d;
  logic [ROOT_W-1:0]   len_q, len_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [14:0]         mdz_q, mdz_d;

  logic                out_valid_q, out_valid_d;
  logic signed [15:0]  vx_q, vx_d, vy_q, vy_d;
  logic                act_q, act_d, pe_q, pe_d, re_q, re_d;

  logic [OPD_W-1:0]    mul_a, mul_b;
  logic [MUL_W-1:0]    prod;

  logic                accept;
  logic                flag_rd;
  logic                flag_we;
  logic                flag_rdata;
  logic                sq_start, dv_start, sq_done, dv_done;
  logic [LEN2_W-1:0]   sq_rad;
  logic [ROOT_W-1:0]   sq_root;
  logic [DVD_W-1:0]    dv_dvd;
  logic [DEN_W-1:0]    dv_den;
  logic [QUO_W-1:0]    dv_quo;

  logic [MAG_W-1:0]    ax_mag, ay_mag;
  logic                ax_sgn, ay_sgn;
  logic [ROOT_W-1:0]   m_len;
  logic [MAG_W-1:0]    cx, cy;
  logic                act_now;

  // Clamp a stick axis to plus or minus one and split it into sign and magnitude.
  function automatic logic [MAG_W:0] clamp_axis(input logic signed [15:0] v);
    logic signed [MAG_W-1:0] e;
    logic [MAG_W-1:0]        m;
    e = MAG_W'(v);
    if (e < 0) begin
      m = MAG_W'(-e);
    end else begin
      m = MAG_W'(e);
    end
    if (m > ONE_M) begin
      m = ONE_M;
    end
    return {v[15], m};
  endfunction

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  assign {ax_sgn, ax_mag} = clamp_axis(stick_x_i);
  assign {ay_sgn, ay_mag} = clamp_axis(stick_y_i);

  // The one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQX: begin
        mul_a = OPD_W'(mx_q);
        mul_b = OPD_W'(mx_q);
      end
      ST_SQY: begin
        mul_a = OPD_W'(my_q);
        mul_b = OPD_W'(my_q);
      end
      ST_DZ: begin
        mul_a = OPD_W'(dz_q);
        mul_b = OPD_W'(dz_q);
      end
      ST_DEN: begin
        mul_a = len_q;
        mul_b = OPD_W'(ONE_Q) - OPD_W'(dz_q);
      end
      ST_NUMX: begin
        mul_a = OPD_W'(mx_q);
        mul_b = OPD_W'(mdz_q);
      end
      ST_NUMY: begin
        mul_a = OPD_W'(my_q);
        mul_b = OPD_W'(mdz_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Shortened length used by the deadzone rescale.
  assign m_len = (len_q < ROOT_W'(ONE_Q)) ? len_q : ROOT_W'(ONE_Q);

  // Output clamp to plus or minus one.
  assign cx      = (mx_q > ONE_M) ? ONE_M : mx_q;
  assign cy      = (my_q > ONE_M) ? ONE_M : my_q;
  assign act_now = (cx != '0) || (cy != '0);

  always_comb begin
    state_d  = state_q;
    ana_d    = ana_q;
    norm_d   = norm_q;
    old_d    = old_q;
    slot_d   = slot_q;
    dz_d     = dz_q;
    sgn_x_d  = sgn_x_q;
    sgn_y_d  = sgn_y_q;
    mx_d     = mx_q;
    my_d     = my_q;
    len2_d   = len2_q;
    len_d    = len_q;
    den_d    = den_q;
    mdz_d    = mdz_q;
    sq_start = 1'b0;
    sq_rad   = len2_q;
    dv_start = 1'b0;
    dv_dvd   = '0;
    dv_den   = den_q;
    flag_rd  = 1'b0;
    flag_we  = 1'b0;

    out_valid_d = out_valid_q && out_stall_i;
    vx_d  = vx_q;
    vy_d  = vy_q;
    act_d = act_q;
    pe_d  = pe_q;
    re_d  = re_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          flag_rd = 1'b1;
          slot_d  = SLOT_W'(slot_i);
          dz_d    = dead_zone_i;
          norm_d  = 1'b0;
          ana_d   = 1'b0;
          sgn_x_d = 1'b0;
          sgn_y_d = 1'b0;
          mx_d    = '0;
          my_d    = '0;
          case (kind_i) inside
            KIND_BUTTON: begin
              mx_d = level_a_i ? ONE_M : '0;
            end
            KIND_BAXIS1D, KIND_BAXIS2D: begin
              mx_d    = (level_a_i ^ level_b_i) ? ONE_M : '0;
              sgn_x_d = level_a_i & ~level_b_i;
              if (kind_i == KIND_BAXIS2D) begin
                my_d    = (level_c_i ^ level_d_i) ? ONE_M : '0;
                sgn_y_d = level_c_i & ~level_d_i;
              end
            end
            KIND_ANA1D, KIND_ANA2D: begin
              if (pad_connected_i) begin
                ana_d   = 1'b1;
                mx_d    = ax_mag;
                sgn_x_d = ax_sgn;
                if (kind_i == KIND_ANA2D) begin
                  my_d    = ay_mag;
                  sgn_y_d = ay_sgn;
                end
              end
            end
            default: begin
              // Undefined kinds give the zero vector.
              mx_d = '0;
            end
          endcase
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        if (!norm_q && !ana_q) begin
          old_d = flag_rdata;
        end
        if (ana_q) begin
          old_d = flag_rdata;
        end
        len2_d  = LEN2_W'(prod);
        state_d = ST_SQY;
      end
      ST_SQY: begin
        len2_d  = len2_q + LEN2_W'(prod);
        state_d = ana_q ? ST_DZ : ST_NCHK;
      end
      ST_DZ: begin
        if (len2_q <= LEN2_W'(prod)) begin
          mx_d    = '0;
          my_d    = '0;
          state_d = ST_OUT;
        end else begin
          sq_start = 1'b1;
          state_d  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          len_d = sq_root;
          if (norm_q) begin
            den_d   = DEN_W'(sq_root);
            state_d = ST_NUMX;
          end else begin
            state_d = ST_DEN;
          end
        end
      end
      ST_DEN: begin
        den_d   = DEN_W'(prod);
        mdz_d   = (m_len > ROOT_W'(dz_q)) ? 15'(m_len - ROOT_W'(dz_q)) : '0;
        state_d = ST_NUMX;
      end
      ST_NUMX, ST_NUMY: begin
        dv_start = 1'b1;
        if (norm_q) begin
          dv_dvd = (DVD_W'((state_q == ST_NUMX) ? mx_q : my_q) << 14)
                   + DVD_W'(den_q >> 1);
        end else begin
          dv_dvd = (DVD_W'(prod) << 14) + DVD_W'(den_q >> 1);
        end
        state_d = (state_q == ST_NUMX) ? ST_DIVX : ST_DIVY;
      end
      ST_DIVX: begin
        if (dv_done) begin
          mx_d    = MAG_W'(dv_quo);
          state_d = ST_NUMY;
        end
      end
      ST_DIVY: begin
        if (dv_done) begin
          my_d = MAG_W'(dv_quo);
          if (norm_q) begin
            state_d = ST_OUT;
          end else begin
            // Rescaled vector goes round once more for the length check.
            ana_d   = 1'b0;
            state_d = ST_SQX;
          end
        end
      end
      ST_NCHK: begin
        if (len2_q > ONE_SQ) begin
          norm_d   = 1'b1;
          sq_start = 1'b1;
          state_d  = ST_ROOT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          flag_we     = 1'b1;
          out_valid_d = 1'b1;
          vx_d  = sgn_x_q ? -16'(cx) : 16'(cx);
          vy_d  = sgn_y_q ? -16'(cy) : 16'(cy);
          act_d = act_now;
          pe_d  = act_now && !old_q;
          re_d  = old_q && !act_now;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  iac_flag_mem u_flag_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (flag_rd),
    .rd_addr_i (SLOT_W'(slot_i)),
    .rd_data_o (flag_rdata),
    .wr_en_i   (flag_we),
    .wr_addr_i (slot_q),
    .wr_data_i (act_now)
  );

  iac_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  iac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .dvd_i   (dv_dvd),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ana_q       <= 1'b0;
      norm_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ana_q       <= ana_d;
      norm_q      <= norm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_q   <= old_d;
    slot_q  <= slot_d;
    dz_q    <= dz_d;
    sgn_x_q <= sgn_x_d;
    sgn_y_q <= sgn_y_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    len2_q  <= len2_d;
    len_q   <= len_d;
    den_q   <= den_d;
    mdz_q   <= mdz_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    act_q   <= act_d;
    pe_q    <= pe_d;
    re_q    <= re_d;
  end

  assign out_valid_o    = out_valid_q;
  assign value_x_o      = vx_q;
  assign value_y_o      = vy_q;
  assign active_o       = act_q;
  assign press_edge_o   = pe_q;
  assign release_edge_o = re_q;

  // The conditioned vector never leaves the unit range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_x_o <= 16'sd16384 && value_x_o >= -16'sd16384 &&
                     value_y_o <= 16'sd16384 && value_y_o >= -16'sd16384))
    else $error("conditioned value out of range");

  // Active must follow the delivered vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_o == ((value_x_o != '0) || (value_y_o != '0))))
    else $error("active flag disagrees with value");

  // A press edge needs an active result, a release edge an idle one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!press_edge_o || active_o) && (!release_edge_o || !active_o)))
    else $error("edge flag inconsistent with active");

  // A result is registered only on the way back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (state_q == ST_IDLE))
    else $error("result loaded outside the final state");

endmodule

>>> dv/input_action_conditioner_tb.sv
`timescale 1ns / 1ps

module input_action_conditioner_tb;
  import iac_pkg::*;

  // One conditioned action value as the block reports it.
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               act;
    logic               press;
    logic               rel;
  } action_value_t;

  // Holds the expected action values in arrival order and checks each result against
  // the oldest of them.
  class action_scoreboard;
    action_value_t pending_q[$];
    int            mismatches;

    function void note_item(action_value_t v);
      pending_q.insert(pending_q.size(), v);
    endfunction

    function void check_result(action_value_t got);
      action_value_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", got.vx, got.vy);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected x=%0d y=%0d a=%0b p=%0b r=%0b, ",
                    "got x=%0d y=%0d a=%0b p=%0b r=%0b"},
                   want.vx, want.vy, want.act, want.press, want.rel,
                   got.vx, got.vy, got.act, got.press, got.rel);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         slot_i = '0;
  logic [2:0]         kind_i = '0;
  logic               level_a_i = 1'b0;
  logic               level_b_i = 1'b0;
  logic               level_c_i = 1'b0;
  logic               level_d_i = 1'b0;
  logic               pad_connected_i = 1'b0;
  logic signed [15:0] stick_x_i = '0;
  logic signed [15:0] stick_y_i = '0;
  logic [13:0]        dead_zone_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] value_x_o;
  logic signed [15:0] value_y_o;
  logic               active_o;
  logic               press_edge_o;
  logic               release_edge_o;

  always #5 clk_i = ~clk_i;

  input_action_conditioner u_top (.*);

  action_scoreboard scoreboard = new();
  bit               slot_pressed[SLOT_COUNT];
  bit               quiet_tail = 1'b0;
  bit               long_hold = 1'b0;
  longint           cycle_count = 0;

  // Rounded square root, same convention as the block: floor, then up when s > r*r + r.
  function automatic longint unsigned round_root(longint unsigned s);
    longint unsigned r = 0;
    longint unsigned bitv = 64'd1 << 62;
    longint unsigned rem = s;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (s > r * r + r) r += 1;
    return r;
  endfunction

  // v * num / den, rounded with halves away from zero.
  function automatic longint scaled_axis(longint v, longint unsigned num, longint unsigned den);
    longint unsigned mag = (v < 0) ? -v : v;
    longint unsigned q = (mag * num + den / 2) / den;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  // Works out the conditioned value for one item and advances the per-slot pressed bit.
  function automatic action_value_t condition_action(
      logic [7:0] slot, logic [2:0] kind, logic la, logic lb, logic lc, logic ld,
      logic conn, logic signed [15:0] sx, logic signed [15:0] sy, logic [13:0] dz);
    action_value_t   v;
    longint          x = 0;
    longint          y = 0;
    longint unsigned len2, len, m, num, den;
    longint unsigned dzl = dz;
    bit              was;
    if (kind == KIND_BUTTON) begin
      x = la * ONE_Q;
    end else if (kind == KIND_BAXIS1D || kind == KIND_BAXIS2D) begin
      x = (longint'(lb) - longint'(la)) * ONE_Q;
      if (kind == KIND_BAXIS2D) y = (longint'(ld) - longint'(lc)) * ONE_Q;
    end else if ((kind == KIND_ANA1D || kind == KIND_ANA2D) && conn) begin
      x = clamp_unit(sx);
      y = (kind == KIND_ANA2D) ? clamp_unit(sy) : 0;
      len2 = x * x + y * y;
      if (len2 <= dzl * dzl) begin
        x = 0;
        y = 0;
      end else begin
        len = round_root(len2);
        m = (len < ONE_Q) ? len : ONE_Q;
        num = (m > dzl) ? (m - dzl) * ONE_Q : 0;
        den = len * (ONE_Q - dzl);
        if (den == 0) den = 1;
        x = scaled_axis(x, num, den);
        y = scaled_axis(y, num, den);
      end
    end
    len2 = x * x + y * y;
    if (len2 > longint'(ONE_Q) * ONE_Q) begin
      len = round_root(len2);
      x = scaled_axis(x, ONE_Q, len);
      y = scaled_axis(y, ONE_Q, len);
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    was = slot_pressed[slot % SLOT_COUNT];
    v.vx = x[15:0];
    v.vy = y[15:0];
    v.act = (x != 0) || (y != 0);
    v.press = v.act && !was;
    v.rel = was && !v.act;
    slot_pressed[slot % SLOT_COUNT] = v.act;
    return v;
  endfunction

  // Offers one item, optionally after a random gap, and waits until it is taken.
  task automatic send_item(logic [7:0] slot, logic [2:0] kind, logic [3:0] lv, logic conn,
                           logic signed [15:0] sx, logic signed [15:0] sy, logic [13:0] dz);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    slot_i          <= slot;
    kind_i          <= kind;
    level_a_i       <= lv[0];
    level_b_i       <= lv[1];
    level_c_i       <= lv[2];
    level_d_i       <= lv[3];
    pad_connected_i <= conn;
    stick_x_i       <= sx;
    stick_y_i       <= sy;
    dead_zone_i     <= dz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scoreboard.note_item(condition_action(slot, kind, lv[0], lv[1], lv[2], lv[3],
                                          conn, sx, sy, dz));
  endtask

  // Stick values lean towards the interesting band around unity and the deadzone edge.
  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      2: return 16'($signed($urandom_range(0, 4000)) - 2000);
      3: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  task automatic send_random_item();
    logic [2:0] kind;
    logic [7:0] slot;
    kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    // A few slots get most of the traffic so that press and release edges occur often.
    slot = $urandom_range(0, 2) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7));
    send_item(slot, kind, 4'($urandom), $urandom_range(0, 7) != 0, pick_axis(), pick_axis(),
              $urandom_range(0, 3) == 0 ? 14'($urandom) : 14'($urandom_range(0, 6000)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (scoreboard.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none at the tail.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Results are sampled at the edge where they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      scoreboard.check_result({value_x_o, value_y_o, active_o, press_edge_o, release_edge_o});
  end

  // Watchdog: even the slowest item, stalls included, stays far inside this bound.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 1_000_000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: each kind, the extreme stick values, deadzone edges and the
    // button diagonal, plus out-of-range kinds and a disconnected pad.
    send_item(8'd0, KIND_BUTTON, 4'b0001, 1'b1, 16'sd0, 16'sd0, 14'd0);
    send_item(8'd0, KIND_BUTTON, 4'b0000, 1'b1, 16'sd0, 16'sd0, 14'd0);
    send_item(8'd1, KIND_BAXIS1D, 4'b0010, 1'b0, 16'sd0, 16'sd0, 14'd0);
    send_item(8'd1, KIND_BAXIS1D, 4'b0011, 1'b0, 16'sd0, 16'sd0, 14'd0);
    send_item(8'd2, KIND_BAXIS2D, 4'b1010, 1'b0, 16'sd0, 16'sd0, 14'd0);
    send_item(8'd2, KIND_BAXIS2D, 4'b0101, 1'b0, 16'sd0, 16'sd0, 14'd0);
    send_item(8'd3, KIND_ANA1D, 4'b0000, 1'b1, 16'sh7fff, 16'sh7fff, 14'd0);
    send_item(8'd3, KIND_ANA1D, 4'b0000, 1'b1, -16'sd32768, 16'sd0, 14'd16383);
    send_item(8'd4, KIND_ANA2D, 4'b0000, 1'b1, -16'sd32768, 16'sh7fff, 14'd0);
    send_item(8'd4, KIND_ANA2D, 4'b0000, 1'b1, 16'sd16384, 16'sd16384, 14'd16383);
    send_item(8'd4, KIND_ANA2D, 4'b0000, 1'b1, 16'sd3000, 16'sd4000, 14'd5000);
    send_item(8'd4, KIND_ANA2D, 4'b0000, 1'b1, 16'sd3000, 16'sd4001, 14'd5000);
    send_item(8'd4, KIND_ANA2D, 4'b0000, 1'b0, 16'sd9000, 16'sd9000, 14'd100);
    send_item(8'd255, 3'd5, 4'b1111, 1'b1, 16'sd9000, 16'sd0, 14'd0);
    send_item(8'd255, 3'd7, 4'b1111, 1'b1, 16'sd9000, 16'sd0, 14'd0);
    send_item(8'd255, KIND_BUTTON, 4'b1111, 1'b1, -16'sd1, -16'sd1, 14'h2aaa);
    send_item(8'd170, KIND_ANA2D, 4'b0000, 1'b1, 16'sh5555, -16'sd21846, 14'h1555);

    // Random part, with one long receiver hold-off that backs the block up.
    for (int i = 0; i < 1400; i++) begin
      if (i == 300) long_hold = 1'b1;
      if (i == 700) wait_drained();
      if (i == 1250) quiet_tail = 1'b1;
      send_random_item();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (scoreboard.mismatches == 0 && scoreboard.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/iac_pkg.sv
rtl/iac_flag_mem.sv
rtl/iac_sqrt.sv
rtl/iac_div.sv
rtl/input_action_conditioner.sv
dv/input_action_conditioner_tb.sv
